[rtl/core/dahdsr_pkg.sv]
package dahdsr_pkg;

   // envelope stage as reported on the result channel
   typedef enum logic [2:0] {
      ST_STOP    = 3'd0,
      ST_DELAY   = 3'd1,
      ST_ATTACK  = 3'd2,
      ST_HOLD    = 3'd3,
      ST_DECAY   = 3'd4,
      ST_SUSTAIN = 3'd5,
      ST_RELEASE = 3'd6
   } stage_type;

   typedef enum logic [1:0] {
      OP_NOTE_ON  = 2'd0,
      OP_NOTE_OFF = 2'd1,
      OP_SAMPLE   = 2'd2,
      OP_RESERVED = 2'd3
   } op_type;

   // divisor used by the timecent digit extraction
   typedef enum logic [1:0] {
      TCD_1200,
      TCD_100,
      TCD_10
   } tc_div_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_DECODE,
      S_ON_INIT,
      S_TC_Q,
      S_TC_H,
      S_TC_T,
      S_TC_M1,
      S_TC_M2,
      S_TC_M3,
      S_TC_SH,
      S_TC_STORE,
      S_TC_LOAD2,
      S_SMP_EVAL,
      S_SMP_MUL,
      S_DIV_START,
      S_DIV_WAIT,
      S_SMP_FIN,
      S_NOTE_OFF,
      S_DONE
   } ctrl_state_type;

   // configuration register indexes
   localparam logic [2:0] CSR_DELAY       = 3'd0;
   localparam logic [2:0] CSR_ATTACK      = 3'd1;
   localparam logic [2:0] CSR_HOLD_TC     = 3'd2;
   localparam logic [2:0] CSR_DECAY_TC    = 3'd3;
   localparam logic [2:0] CSR_SUSTAIN     = 3'd4;
   localparam logic [2:0] CSR_RELEASE     = 3'd5;
   localparam logic [2:0] CSR_KEY_HOLD    = 3'd6;
   localparam logic [2:0] CSR_KEY_DECAY   = 3'd7;

   localparam logic signed [24:0] LVL_MIN   = -25'sd9437184;
   localparam logic signed [24:0] LVL_MAX   = 25'sd0;
   localparam logic signed [24:0] LVL_RESET = -25'sd6553600;
   localparam logic [23:0]        LVL_SPAN  = 24'd9437184;

   localparam logic signed [7:0]  KEY_CENTER = 8'sd60;
   localparam logic signed [20:0] TC_LOW     = -21'sd12000;
   localparam logic signed [20:0] TC_HIGH    = 21'sd8000;
   localparam logic [14:0]        TC_RANGE   = 15'd20000;
   localparam logic signed [14:0] TC_RESET   = -15'sd12000;
   localparam logic [31:0]        US_RESET   = 32'd1000;
   localparam logic [19:0]        US_SCALE   = 20'd1000000;
   localparam int                 DIV_STEPS  = 24;

   typedef struct packed {
      logic       accept;
      logic       on_init;
      logic       tc_load;
      logic       tc_sel;
      logic       tc_step;
      tc_div_type tc_div;
      logic       tc_mul1;
      logic       tc_mul2;
      logic       tc_mul3;
      logic       tc_shift;
      logic       tc_store;
      logic       tc_pass;
      logic       smp_eval;
      logic       smp_mul;
      logic       div_start;
      logic       smp_fin;
      logic       note_off;
      logic       out_load;
   } cmd_type;

   typedef struct packed {
      op_type op;
      logic   stopped;
      logic   tc_ge;
      logic   div_busy;
   } status_type;

   // 2^(k/12) in Q16
   function automatic logic [16:0] semi_q16(input logic [3:0] idx);
      logic [16:0] val;
      unique case (idx)
         4'd0:    val = 17'd65536;
         4'd1:    val = 17'd69433;
         4'd2:    val = 17'd73562;
         4'd3:    val = 17'd77936;
         4'd4:    val = 17'd82570;
         4'd5:    val = 17'd87480;
         4'd6:    val = 17'd92682;
         4'd7:    val = 17'd98193;
         4'd8:    val = 17'd104032;
         4'd9:    val = 17'd110218;
         4'd10:   val = 17'd116772;
         4'd11:   val = 17'd123715;
         default: val = 17'd65536;
      endcase
      return val;
   endfunction

   // 2^(k/120) in Q16
   function automatic logic [16:0] deci_q16(input logic [3:0] idx);
      logic [16:0] val;
      unique case (idx)
         4'd0:    val = 17'd65536;
         4'd1:    val = 17'd65916;
         4'd2:    val = 17'd66297;
         4'd3:    val = 17'd66682;
         4'd4:    val = 17'd67068;
         4'd5:    val = 17'd67456;
         4'd6:    val = 17'd67847;
         4'd7:    val = 17'd68240;
         4'd8:    val = 17'd68635;
         4'd9:    val = 17'd69033;
         default: val = 17'd65536;
      endcase
      return val;
   endfunction

   // 2^(k/1200) in Q16
   function automatic logic [16:0] cent_q16(input logic [3:0] idx);
      logic [16:0] val;
      unique case (idx)
         4'd0:    val = 17'd65536;
         4'd1:    val = 17'd65574;
         4'd2:    val = 17'd65612;
         4'd3:    val = 17'd65650;
         4'd4:    val = 17'd65688;
         4'd5:    val = 17'd65726;
         4'd6:    val = 17'd65764;
         4'd7:    val = 17'd65802;
         4'd8:    val = 17'd65840;
         4'd9:    val = 17'd65878;
         default: val = 17'd65536;
      endcase
      return val;
   endfunction

endpackage

[rtl/core/dahdsr_div.sv]
// restoring divider, one quotient bit a cycle; quotient known to fit 24 bits
module dahdsr_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [55:0] dividend,
   input  logic [31:0] divisor,
   output logic        busy,
   output logic [23:0] quotient
);

   logic [31:0] rem_ff, rem_in;
   logic [23:0] quo_ff, quo_in;
   logic [31:0] dv_ff, dv_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic [32:0] trial;

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dv_in   = dv_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      trial   = {rem_ff, quo_ff[23]};
      if (start) begin
         rem_in  = dividend[55:24];
         quo_in  = dividend[23:0];
         dv_in   = divisor;
         cnt_in  = 5'(dahdsr_pkg::DIV_STEPS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dv_ff}) begin
            rem_in = 32'(trial - {1'b0, dv_ff});
            quo_in = {quo_ff[22:0], 1'b1};
         end else begin
            rem_in = trial[31:0];
            quo_in = {quo_ff[22:0], 1'b0};
         end
         cnt_in = cnt_ff - 5'd1;
         if (cnt_ff == 5'd1) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dv_ff  <= dv_in;
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;

endmodule

[rtl/core/dahdsr_dp.sv]
module dahdsr_dp (
   input  logic                   clock,
   input  logic                   reset,
   input  dahdsr_pkg::cmd_type    cmd,
   output dahdsr_pkg::status_type status,
   input  logic [71:0]            req_tdata,
   input  logic [2:0]             req_tuser,
   input  logic                   csr_we,
   input  logic [2:0]             csr_index,
   input  logic [31:0]            csr_wdata,
   output logic [31:0]            rsp_tdata
);

   // configuration
   logic [31:0]        delay_ff, attack_ff;
   logic signed [14:0] hold_tc_ff, decay_tc_ff;
   logic signed [24:0] sustain_ff;
   logic signed [11:0] key_hold_ff, key_decay_ff;

   // latched request
   dahdsr_pkg::op_type in_op_ff;
   logic [6:0]         in_key_ff;
   logic [31:0]        in_time_ff, in_ovr_ff;
   logic               in_has_ff;
   logic [31:0]        e_ff;

   // envelope state
   dahdsr_pkg::stage_type phase_ff;
   logic               key_down_ff;
   logic [31:0]        open_time_ff;
   logic [33:0]        attack_end_ff, hold_end_ff, decay_end_ff;
   logic [31:0]        active_rel_ff, saved_rel_ff;
   logic               saved_valid_ff;
   logic [31:0]        rel_start_ff;
   logic [33:0]        rel_end_ff;
   logic signed [24:0] rel_peak_ff, cur_level_ff, csus_ff;

   // timecent conversion
   logic [14:0] tc_rem_ff;
   logic [4:0]  tc_q_ff;
   logic [3:0]  tc_h_ff, tc_d_ff;
   logic [17:0] tc_m_ff;
   logic [37:0] tc_v_ff;
   logic [27:0] tc_res_ff;

   // sample evaluation
   dahdsr_pkg::stage_type sm_phase_ff;
   logic signed [24:0] sm_base_ff;
   logic               sm_sub_ff, sm_full_ff, sm_rel_ff;
   logic [23:0]        sm_span_ff;
   logic [31:0]        sm_num_ff, sm_den_ff;
   logic [55:0]        prod_ff;

   logic signed [24:0] out_level_ff;
   dahdsr_pkg::stage_type out_stage_ff;

   logic        div_busy;
   logic [23:0] div_q;

   dahdsr_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (prod_ff),
      .divisor  (sm_den_ff),
      .busy     (div_busy),
      .quotient (div_q)
   );

   // ---- timecent load: clamp(tc + scale*(key-60)) + 12000
   logic signed [7:0]  kd;
   logic signed [14:0] tc_sel_tc;
   logic signed [11:0] tc_sel_scale;
   logic signed [19:0] kprod;
   logic signed [20:0] tc_sum;
   logic [14:0]        tc_t;
   logic [14:0]        tc_dv;
   logic               tc_ge;

   always_comb begin
      kd           = $signed({1'b0, in_key_ff}) - dahdsr_pkg::KEY_CENTER;
      tc_sel_tc    = cmd.tc_sel ? decay_tc_ff : hold_tc_ff;
      tc_sel_scale = cmd.tc_sel ? key_decay_ff : key_hold_ff;
      kprod        = tc_sel_scale * kd;
      tc_sum       = 21'(tc_sel_tc) + 21'(kprod);
      priority if (tc_sum < dahdsr_pkg::TC_LOW) begin
         tc_t = '0;
      end else if (tc_sum > dahdsr_pkg::TC_HIGH) begin
         tc_t = dahdsr_pkg::TC_RANGE;
      end else begin
         tc_t = 15'(tc_sum - dahdsr_pkg::TC_LOW);
      end
      unique case (cmd.tc_div)
         dahdsr_pkg::TCD_1200: tc_dv = 15'd1200;
         dahdsr_pkg::TCD_100:  tc_dv = 15'd100;
         dahdsr_pkg::TCD_10:   tc_dv = 15'd10;
         default:              tc_dv = 15'd10;
      endcase
      tc_ge = tc_rem_ff >= tc_dv;
   end

   // ---- final scaling: 1e6 * m, shifted by the octave count with rounding
   logic [43:0] tc_up;
   logic [44:0] tc_rnd;
   logic [4:0]  tc_sh;
   logic [27:0] tc_out;

   always_comb begin
      tc_up  = '0;
      tc_rnd = '0;
      tc_sh  = 5'd26 - tc_q_ff;
      if (tc_q_ff >= 5'd10) begin
         tc_up  = {6'd0, tc_v_ff} << (tc_q_ff - 5'd10);
         tc_rnd = {1'b0, tc_up} + 45'd32768;
         tc_out = tc_rnd[43:16];
      end else begin
         tc_rnd = {7'd0, tc_v_ff} + (45'd1 << (tc_sh - 5'd1));
         tc_out = 28'(tc_rnd >> tc_sh);
      end
   end

   // ---- sample: pick stage, ramp span and fraction
   logic [33:0]        e34, ev_num, ev_den, ev_numc, ev_numn, ev_denn;
   dahdsr_pkg::stage_type ev_phase;
   logic signed [24:0] ev_base;
   logic               ev_sub, ev_full;
   logic [23:0]        ev_span;

   always_comb begin
      e34      = {2'b0, e_ff};
      ev_phase = dahdsr_pkg::ST_STOP;
      ev_base  = dahdsr_pkg::LVL_MIN;
      ev_sub   = 1'b0;
      ev_full  = 1'b0;
      ev_span  = '0;
      ev_num   = '0;
      ev_den   = 34'd1;
      if (key_down_ff) begin
         priority if (e34 < {2'b0, delay_ff}) begin
            ev_phase = dahdsr_pkg::ST_DELAY;
         end else if (e34 < attack_end_ff) begin
            ev_phase = dahdsr_pkg::ST_ATTACK;
            ev_span  = dahdsr_pkg::LVL_SPAN;
            ev_num   = e34 - {2'b0, delay_ff};
            ev_den   = attack_end_ff - {2'b0, delay_ff};
         end else if (e34 < hold_end_ff) begin
            ev_phase = dahdsr_pkg::ST_HOLD;
            ev_base  = dahdsr_pkg::LVL_MAX;
         end else if (e34 < decay_end_ff) begin
            ev_phase = dahdsr_pkg::ST_DECAY;
            ev_base  = dahdsr_pkg::LVL_MAX;
            ev_sub   = 1'b1;
            ev_span  = 24'(dahdsr_pkg::LVL_MAX - csus_ff);
            ev_num   = e34 - hold_end_ff;
            ev_den   = decay_end_ff - hold_end_ff;
         end else begin
            ev_phase = dahdsr_pkg::ST_SUSTAIN;
            ev_base  = csus_ff;
         end
      end else if (e34 < rel_end_ff) begin
         ev_phase = dahdsr_pkg::ST_RELEASE;
         ev_base  = rel_peak_ff;
         ev_sub   = 1'b1;
         ev_span  = 24'(rel_peak_ff - dahdsr_pkg::LVL_MIN);
         ev_num   = (e_ff >= rel_start_ff) ? {2'b0, e_ff - rel_start_ff} : '0;
         ev_den   = {2'b0, active_rel_ff};
         ev_full  = (active_rel_ff == '0);
      end
      ev_numc = (ev_num > ev_den) ? ev_den : ev_num;
      // bring the denominator down to 32 bits
      priority if (ev_den[33]) begin
         ev_numn = ev_numc >> 2;
         ev_denn = ev_den >> 2;
      end else if (ev_den[32]) begin
         ev_numn = ev_numc >> 1;
         ev_denn = ev_den >> 1;
      end else begin
         ev_numn = ev_numc;
         ev_denn = ev_den;
      end
   end

   logic signed [24:0] fin_q, fin_lv;
   dahdsr_pkg::stage_type fin_phase;

   always_comb begin
      fin_q     = sm_full_ff ? $signed({1'b0, sm_span_ff}) : $signed({1'b0, div_q});
      fin_lv    = sm_sub_ff ? (sm_base_ff - fin_q) : (sm_base_ff + fin_q);
      fin_phase = (sm_rel_ff && fin_lv == dahdsr_pkg::LVL_MIN) ? dahdsr_pkg::ST_STOP
                                                               : sm_phase_ff;
   end

   logic signed [34:0] off_diff;
   logic               off_keep;

   always_comb begin
      off_diff = $signed({1'b0, rel_end_ff}) - $signed({3'b0, e_ff});
      off_keep = off_diff < $signed({3'b0, in_ovr_ff});
   end

   // ---- control-bearing state
   always_ff @(posedge clock) begin
      if (reset) begin
         delay_ff       <= '0;
         attack_ff      <= dahdsr_pkg::US_RESET;
         hold_tc_ff     <= dahdsr_pkg::TC_RESET;
         decay_tc_ff    <= dahdsr_pkg::TC_RESET;
         sustain_ff     <= '0;
         key_hold_ff    <= '0;
         key_decay_ff   <= '0;
         phase_ff       <= dahdsr_pkg::ST_STOP;
         key_down_ff    <= 1'b0;
         open_time_ff   <= '0;
         attack_end_ff  <= '0;
         hold_end_ff    <= '0;
         decay_end_ff   <= '0;
         active_rel_ff  <= dahdsr_pkg::US_RESET;
         saved_rel_ff   <= '0;
         saved_valid_ff <= 1'b0;
         rel_start_ff   <= '0;
         rel_end_ff     <= '0;
         rel_peak_ff    <= '0;
         cur_level_ff   <= dahdsr_pkg::LVL_RESET;
         csus_ff        <= '0;
      end else begin
         if (cmd.on_init) begin
            phase_ff      <= dahdsr_pkg::ST_DELAY;
            key_down_ff   <= 1'b1;
            open_time_ff  <= in_time_ff;
            attack_end_ff <= {2'b0, delay_ff} + {2'b0, attack_ff};
            if (saved_valid_ff && saved_rel_ff != '0) begin
               active_rel_ff <= saved_rel_ff;
            end
            priority if (sustain_ff < dahdsr_pkg::LVL_MIN) begin
               csus_ff <= dahdsr_pkg::LVL_MIN;
            end else if (sustain_ff > dahdsr_pkg::LVL_MAX) begin
               csus_ff <= dahdsr_pkg::LVL_MAX;
            end else begin
               csus_ff <= sustain_ff;
            end
         end
         if (cmd.tc_store) begin
            if (cmd.tc_pass) begin
               decay_end_ff <= hold_end_ff + {6'd0, tc_res_ff};
            end else begin
               hold_end_ff <= attack_end_ff + {6'd0, tc_res_ff};
            end
         end
         if (cmd.smp_fin) begin
            phase_ff     <= fin_phase;
            cur_level_ff <= fin_lv;
            if (!sm_rel_ff) begin
               rel_start_ff <= e_ff;
               rel_peak_ff  <= fin_lv;
               rel_end_ff   <= {2'b0, e_ff} + {2'b0, active_rel_ff};
            end
         end
         if (cmd.note_off) begin
            phase_ff <= dahdsr_pkg::ST_RELEASE;
            if (key_down_ff) begin
               key_down_ff <= 1'b0;
               if (in_has_ff) begin
                  if (!saved_valid_ff) begin
                     saved_rel_ff   <= active_rel_ff;
                     saved_valid_ff <= 1'b1;
                  end
                  active_rel_ff <= in_ovr_ff;
               end
            end
            if (in_has_ff && !off_keep) begin
               rel_start_ff <= e_ff;
               rel_peak_ff  <= cur_level_ff;
               rel_end_ff   <= {2'b0, e_ff} + {2'b0, in_ovr_ff};
            end
         end
         if (csr_we) begin
            unique case (csr_index)
               dahdsr_pkg::CSR_DELAY:     delay_ff      <= csr_wdata;
               dahdsr_pkg::CSR_ATTACK:    attack_ff     <= csr_wdata;
               dahdsr_pkg::CSR_HOLD_TC:   hold_tc_ff    <= $signed(csr_wdata[14:0]);
               dahdsr_pkg::CSR_DECAY_TC:  decay_tc_ff   <= $signed(csr_wdata[14:0]);
               dahdsr_pkg::CSR_SUSTAIN:   sustain_ff    <= $signed(csr_wdata[24:0]);
               dahdsr_pkg::CSR_RELEASE:   active_rel_ff <= csr_wdata;
               dahdsr_pkg::CSR_KEY_HOLD:  key_hold_ff   <= $signed(csr_wdata[11:0]);
               dahdsr_pkg::CSR_KEY_DECAY: key_decay_ff  <= $signed(csr_wdata[11:0]);
               default: ;
            endcase
         end
      end
   end

   // ---- payload registers
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         in_op_ff   <= dahdsr_pkg::op_type'(req_tuser[1:0]);
         in_has_ff  <= req_tuser[2];
         in_key_ff  <= req_tdata[6:0];
         in_time_ff <= req_tdata[38:7];
         in_ovr_ff  <= req_tdata[70:39];
         // note-on samples at zero elapsed time
         e_ff <= (dahdsr_pkg::op_type'(req_tuser[1:0]) == dahdsr_pkg::OP_NOTE_ON) ? '0
                 : req_tdata[38:7] - open_time_ff;
      end
      if (cmd.tc_load) begin
         tc_rem_ff <= tc_t;
         tc_q_ff   <= '0;
         tc_h_ff   <= '0;
         tc_d_ff   <= '0;
      end
      if (cmd.tc_step && tc_ge) begin
         tc_rem_ff <= tc_rem_ff - tc_dv;
         unique case (cmd.tc_div)
            dahdsr_pkg::TCD_1200: tc_q_ff <= tc_q_ff + 5'd1;
            dahdsr_pkg::TCD_100:  tc_h_ff <= tc_h_ff + 4'd1;
            dahdsr_pkg::TCD_10:   tc_d_ff <= tc_d_ff + 4'd1;
            default: ;
         endcase
      end
      if (cmd.tc_mul1) begin
         tc_m_ff <= 18'(({17'd0, dahdsr_pkg::semi_q16(tc_h_ff)} *
                          {17'd0, dahdsr_pkg::deci_q16(tc_d_ff)} + 34'd32768) >> 16);
      end
      if (cmd.tc_mul2) begin
         tc_m_ff <= 18'(({17'd0, tc_m_ff} * {18'd0, dahdsr_pkg::cent_q16(tc_rem_ff[3:0])}
                         + 35'd32768) >> 16);
      end
      if (cmd.tc_mul3) begin
         tc_v_ff <= {20'd0, tc_m_ff} * {18'd0, dahdsr_pkg::US_SCALE};
      end
      if (cmd.tc_shift) begin
         tc_res_ff <= tc_out;
      end
      if (cmd.smp_eval) begin
         sm_phase_ff <= ev_phase;
         sm_base_ff  <= ev_base;
         sm_sub_ff   <= ev_sub;
         sm_full_ff  <= ev_full;
         sm_rel_ff   <= !key_down_ff;
         sm_span_ff  <= ev_span;
         sm_num_ff   <= ev_numn[31:0];
         sm_den_ff   <= ev_denn[31:0];
      end
      if (cmd.smp_mul) begin
         prod_ff <= {32'd0, sm_span_ff} * {24'd0, sm_num_ff};
      end
      if (cmd.out_load) begin
         out_stage_ff <= phase_ff;
         out_level_ff <= (phase_ff == dahdsr_pkg::ST_STOP) ? dahdsr_pkg::LVL_MIN : cur_level_ff;
      end
   end

   assign status.op       = in_op_ff;
   assign status.stopped  = (phase_ff == dahdsr_pkg::ST_STOP);
   assign status.tc_ge    = tc_ge;
   assign status.div_busy = div_busy;

   assign rsp_tdata = {4'd0, out_stage_ff, out_level_ff};

endmodule

[rtl/core/dahdsr_ctrl.sv]
module dahdsr_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  dahdsr_pkg::status_type status,
   output dahdsr_pkg::cmd_type    cmd
);

   dahdsr_pkg::ctrl_state_type state_ff, state_in;
   logic pass_ff, pass_in;
   logic rsp_valid_ff, rsp_valid_in;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         dahdsr_pkg::S_IDLE: begin
            if (req_tvalid) state_in = dahdsr_pkg::S_DECODE;
         end
         dahdsr_pkg::S_DECODE: begin
            unique case (status.op)
               dahdsr_pkg::OP_NOTE_ON:
                  state_in = status.stopped ? dahdsr_pkg::S_ON_INIT : dahdsr_pkg::S_DONE;
               dahdsr_pkg::OP_NOTE_OFF:
                  state_in = status.stopped ? dahdsr_pkg::S_DONE : dahdsr_pkg::S_NOTE_OFF;
               dahdsr_pkg::OP_SAMPLE:
                  state_in = status.stopped ? dahdsr_pkg::S_DONE : dahdsr_pkg::S_SMP_EVAL;
               default:
                  state_in = dahdsr_pkg::S_DONE;
            endcase
         end
         dahdsr_pkg::S_ON_INIT:  state_in = dahdsr_pkg::S_TC_Q;
         dahdsr_pkg::S_TC_Q:     if (!status.tc_ge) state_in = dahdsr_pkg::S_TC_H;
         dahdsr_pkg::S_TC_H:     if (!status.tc_ge) state_in = dahdsr_pkg::S_TC_T;
         dahdsr_pkg::S_TC_T:     if (!status.tc_ge) state_in = dahdsr_pkg::S_TC_M1;
         dahdsr_pkg::S_TC_M1:    state_in = dahdsr_pkg::S_TC_M2;
         dahdsr_pkg::S_TC_M2:    state_in = dahdsr_pkg::S_TC_M3;
         dahdsr_pkg::S_TC_M3:    state_in = dahdsr_pkg::S_TC_SH;
         dahdsr_pkg::S_TC_SH:    state_in = dahdsr_pkg::S_TC_STORE;
         dahdsr_pkg::S_TC_STORE:
            state_in = pass_ff ? dahdsr_pkg::S_SMP_EVAL : dahdsr_pkg::S_TC_LOAD2;
         dahdsr_pkg::S_TC_LOAD2:  state_in = dahdsr_pkg::S_TC_Q;
         dahdsr_pkg::S_SMP_EVAL:  state_in = dahdsr_pkg::S_SMP_MUL;
         dahdsr_pkg::S_SMP_MUL:   state_in = dahdsr_pkg::S_DIV_START;
         dahdsr_pkg::S_DIV_START: state_in = dahdsr_pkg::S_DIV_WAIT;
         dahdsr_pkg::S_DIV_WAIT:  if (!status.div_busy) state_in = dahdsr_pkg::S_SMP_FIN;
         dahdsr_pkg::S_SMP_FIN:   state_in = dahdsr_pkg::S_DONE;
         dahdsr_pkg::S_NOTE_OFF:  state_in = dahdsr_pkg::S_DONE;
         dahdsr_pkg::S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) state_in = dahdsr_pkg::S_IDLE;
         end
         default: state_in = dahdsr_pkg::S_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd        = '0;
      cmd.tc_div = dahdsr_pkg::TCD_10;
      cmd.tc_pass = pass_ff;
      pass_in    = pass_ff;
      req_tready = 1'b0;
      unique case (state_ff)
         dahdsr_pkg::S_IDLE: begin
            req_tready = 1'b1;
            cmd.accept = req_tvalid;
         end
         dahdsr_pkg::S_ON_INIT: begin
            cmd.on_init = 1'b1;
            cmd.tc_load = 1'b1;
            pass_in     = 1'b0;
         end
         dahdsr_pkg::S_TC_Q: begin
            cmd.tc_step = 1'b1;
            cmd.tc_div  = dahdsr_pkg::TCD_1200;
         end
         dahdsr_pkg::S_TC_H: begin
            cmd.tc_step = 1'b1;
            cmd.tc_div  = dahdsr_pkg::TCD_100;
         end
         dahdsr_pkg::S_TC_T: begin
            cmd.tc_step = 1'b1;
            cmd.tc_div  = dahdsr_pkg::TCD_10;
         end
         dahdsr_pkg::S_TC_M1:    cmd.tc_mul1  = 1'b1;
         dahdsr_pkg::S_TC_M2:    cmd.tc_mul2  = 1'b1;
         dahdsr_pkg::S_TC_M3:    cmd.tc_mul3  = 1'b1;
         dahdsr_pkg::S_TC_SH:    cmd.tc_shift = 1'b1;
         dahdsr_pkg::S_TC_STORE: cmd.tc_store = 1'b1;
         dahdsr_pkg::S_TC_LOAD2: begin
            cmd.tc_load = 1'b1;
            cmd.tc_sel  = 1'b1;
            pass_in     = 1'b1;
         end
         dahdsr_pkg::S_SMP_EVAL:  cmd.smp_eval  = 1'b1;
         dahdsr_pkg::S_SMP_MUL:   cmd.smp_mul   = 1'b1;
         dahdsr_pkg::S_DIV_START: cmd.div_start = 1'b1;
         dahdsr_pkg::S_SMP_FIN:   cmd.smp_fin   = 1'b1;
         dahdsr_pkg::S_NOTE_OFF:  cmd.note_off  = 1'b1;
         dahdsr_pkg::S_DONE:      cmd.out_load  = !rsp_valid_ff || rsp_tready;
         default: ;
      endcase
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dahdsr_pkg::S_IDLE;
         pass_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pass_ff      <= pass_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

[rtl/core/dahdsr_envelope_generator.sv]
// Time-stamped DAHDSR envelope (delay, attack, hold, decay, sustain, release) with
// levels in dB as signed Q8.16 (-144 dB to 0 dB) and time in microseconds. Each
// request is a note-on, note-off or sample and yields exactly one response with
// the level and stage after it. Note-on is honoured only while stopped; it takes
// the hold and decay lengths from timecents scaled per key away from 60, clamped
// to -12000..8000 and converted as 2^(tc/1200) through a three-digit table product.
// One request is in work at a time; a finished response waits in an output
// register. From acceptance to the response register, an ignored request goes
// from decode straight to the response and a note-off through its release update;
// a sample runs the 24-step restoring divider of the ramp; a note-on runs the digit
// extraction of the two timecent conversions (at most 35 subtract steps each)
// followed by one sample. Configuration is taken through csr_*
// whenever the block is idle.
module dahdsr_envelope_generator (
   input  logic        clock,
   input  logic        reset,
   // request
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,   // key[6:0], time_us[38:7], release_override_us[70:39]
   input  logic [2:0]  req_tuser,   // op[1:0], has_release_override[2]
   // response
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // level[24:0], stage[27:25]
   // configuration
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   dahdsr_pkg::cmd_type    cmd;
   dahdsr_pkg::status_type status;

   // sequencer: decode, timecent conversion, ramp and response hand-off
   dahdsr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // envelope state, configuration, arithmetic and the response register
   dahdsr_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_tdata (rsp_tdata)
   );

   // a stopped envelope always reports the floor level
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[27:25] == dahdsr_pkg::ST_STOP
      |-> $signed(rsp_tdata[24:0]) == dahdsr_pkg::LVL_MIN)
      else $error("stopped response with level above floor");

   // level never rises above full scale
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[24] || rsp_tdata[23:0] == '0))
      else $error("response level above 0 dB");

   // one request in work at a time
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second request taken while busy");

endmodule
